// ===== rtl/cpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants of the configuration port block: status codes,
// access sizes, configuration space layout and the request/result records
// passed between the sequencer and the access unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

    // Configuration space layout. The space is held as 32-bit words.
    localparam int unsigned CfgSpaceBytes = 256;
    localparam int unsigned CfgWords      = CfgSpaceBytes / 4;
    localparam int unsigned WordIdxW      = $clog2(CfgWords);

    // Byte offsets of the first BAR slot and of the MSAC dword.
    localparam int unsigned FirstBarOffset = 16;
    localparam int unsigned MsacOffset     = 96;
    localparam int unsigned NumBars        = 3;

    // A register offset that is not dword aligned can never be hit.
    localparam bit BarAligned  = (FirstBarOffset % 4) == 0;
    localparam bit MsacAligned = (MsacOffset % 4) == 0;

    localparam logic [WordIdxW-1:0] MsacWord = WordIdxW'(MsacOffset / 4);

    // Configuration register indexes.
    localparam logic [1:0] RegBar0Size = 2'd0;
    localparam logic [1:0] RegBar1Size = 2'd1;
    localparam logic [1:0] RegBar2Size = 2'd2;

    localparam logic [31:0] BarSizeReset = 32'd4096;

    // Access sizes in bytes.
    localparam logic [2:0] SizeByte  = 3'd1;
    localparam logic [2:0] SizeWord  = 3'd2;
    localparam logic [2:0] SizeDword = 3'd4;

    localparam logic OpRead  = 1'b0;
    localparam logic OpWrite = 1'b1;

    localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REJECT  = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef struct packed {
        logic                opcode;
        logic [2:0]          port_offset;
        logic [2:0]          access_size;
        logic [31:0]         write_data;
        logic [WordIdxW-1:0] word_idx;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        t_status     status;
        logic        mem_we;
        logic [31:0] mem_wdata;
        logic        latch_we;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/cpe_cfg_ram.sv =====
// ----------------------------------------------------------------------------
// cpe_cfg_ram
// Configuration space storage: one word per dword of the space, with a
// registered (synchronous) read. A valid bit per word makes the whole space
// read as zero right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_cfg_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [cpe_pkg::WordIdxW-1:0] i_rd_idx,
    input  wire logic                         i_wr_en,
    input  wire logic [cpe_pkg::WordIdxW-1:0] i_wr_idx,
    input  wire logic [31:0]                  i_wr_data,
    output logic      [31:0]                  o_rd_data
);

    logic [31:0]                  r_mem [cpe_pkg::CfgWords];
    logic [cpe_pkg::CfgWords-1:0] r_valid;
    logic [31:0]                  r_rd_data;
    logic                         r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/cpe_access_unit.sv =====
// ----------------------------------------------------------------------------
// cpe_access_unit
// Decodes one port transaction against the address latch and the word read
// from configuration space, and forms the result, the merged write-back word
// and the latch load.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_access_unit (
    input  wire cpe_pkg::t_req                            i_req,
    input  wire logic [31:0]                              i_addr_latch,
    input  wire logic [31:0]                              i_word,
    input  wire logic [cpe_pkg::NumBars-1:0][31:0]        i_region_size,
    output cpe_pkg::t_result                              o_result
);

    logic [1:0]  low;
    logic        size_ok;
    logic [31:0] rd_mask;
    logic [3:0]  lane_en;
    logic [31:0] wdata_shift;
    logic [31:0] merged;
    logic        bar_hit;
    logic [31:0] region_size;
    logic [31:0] bar_val;

    always_comb begin
        low = i_req.port_offset[1:0];

        // Accesses never cross a dword: size 2 needs an even offset, size 4
        // needs offset zero.
        size_ok = (i_req.access_size == cpe_pkg::SizeByte)
               || (i_req.access_size == cpe_pkg::SizeWord && !low[0])
               || (i_req.access_size == cpe_pkg::SizeDword && low == 2'd0);

        case (i_req.access_size)
            cpe_pkg::SizeByte: begin
                rd_mask = 32'h0000_00FF;
                lane_en = 4'b0001 << low;
            end
            cpe_pkg::SizeWord: begin
                rd_mask = 32'h0000_FFFF;
                lane_en = 4'b0011 << low;
            end
            default: begin
                rd_mask = 32'hFFFF_FFFF;
                lane_en = 4'b1111;
            end
        endcase

        wdata_shift = i_req.write_data << {low, 3'b000};
        for (int k = 0; k < 4; k++) begin
            merged[8*k +: 8] = lane_en[k] ? wdata_shift[8*k +: 8] : i_word[8*k +: 8];
        end

        bar_hit     = 1'b0;
        region_size = '0;
        for (int i = 0; i < cpe_pkg::NumBars; i++) begin
            if (cpe_pkg::BarAligned && i_req.word_idx ==
                    cpe_pkg::WordIdxW'(cpe_pkg::FirstBarOffset / 4 + 2 * i)) begin
                bar_hit     = 1'b1;
                region_size = i_region_size[i];
            end
        end

        // Sizing probe: an all-ones write stores the region's size mask.
        bar_val = (i_req.write_data == cpe_pkg::AllOnes)
                ? (i_req.write_data & ~(region_size - 32'd1))
                : i_req.write_data;

        o_result           = '0;
        o_result.status    = cpe_pkg::ST_DONE;
        o_result.mem_wdata = merged;

        if (!size_ok) begin
            o_result.status = cpe_pkg::ST_REJECT;
        end else if (!i_req.port_offset[2]) begin
            // Address port.
            if (i_req.opcode == cpe_pkg::OpWrite) begin
                if (i_req.access_size == cpe_pkg::SizeDword) begin
                    o_result.latch_we = 1'b1;
                end else begin
                    o_result.status = cpe_pkg::ST_REJECT;
                end
            end else begin
                o_result.read_data = (i_addr_latch >> {low, 3'b000}) & rd_mask;
            end
        end else if (i_req.opcode == cpe_pkg::OpWrite) begin
            if (bar_hit) begin
                if (i_req.access_size != cpe_pkg::SizeDword) begin
                    o_result.status = cpe_pkg::ST_REJECT;
                end else begin
                    o_result.mem_we    = 1'b1;
                    o_result.mem_wdata = {bar_val[31:4], i_word[3:0]};
                end
            end else if (cpe_pkg::MsacAligned && i_req.word_idx == cpe_pkg::MsacWord) begin
                o_result.status = cpe_pkg::ST_IGNORED;
            end else begin
                o_result.mem_we = 1'b1;
            end
        end else begin
            o_result.read_data = (i_word >> {low, 3'b000}) & rd_mask;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pci_config_port_emulator.sv =====
// ----------------------------------------------------------------------------
// pci_config_port_emulator
// Port block of PCI configuration mechanism 1 with BAR sizing.
//
// One input transaction is one access to the eight I/O ports: offsets 0..3
// form the 32-bit address port, offsets 4..7 the data port. Each accepted
// transaction returns exactly one result transaction with the read data
// (zero-extended, zero for writes) and a status code.
// Timing: the transaction is taken in S_IDLE, which also issues the read of
// the addressed configuration dword from the registered word memory; in
// S_EXEC the dword is merged and written back and the output register is
// loaded, after which the result is valid on the master side. The block
// takes no new transaction while one is in S_EXEC.
// The next transaction is taken while a result still waits in the output
// register; a stalled receiver then holds that transaction in S_EXEC
// until the output register is free.
// Reset clears the address latch, the BAR sizes (to 4096) and, through one
// valid bit per dword, the whole configuration space at once; no clearing
// pass is needed. The user must write BAR sizes through the i_cfg_we port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_config_port_emulator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] opcode, [3:1] port_offset, [6:4] access_size, [38:7] write_data
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] read_data, [33:32] status
    output logic      [39:0] m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                                  r_state;
    cpe_pkg::t_req                           r_req;
    logic [31:0]                             r_addr_latch;
    logic [cpe_pkg::NumBars-1:0][31:0]       r_region_size;
    logic                                    r_out_valid;
    logic [31:0]                             r_out_rdata;
    cpe_pkg::t_status                        r_out_status;

    cpe_pkg::t_req                           n_req;
    cpe_pkg::t_result                        result;
    logic [31:0]                             mem_word;
    logic                                    s_accept;
    logic                                    out_free;
    logic                                    exec_done;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign exec_done     = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_req.opcode      = s_axis_tdata[0];
        n_req.port_offset = s_axis_tdata[3:1];
        n_req.access_size = s_axis_tdata[6:4];
        n_req.write_data  = s_axis_tdata[38:7];
        n_req.word_idx    = r_addr_latch[7:2];
    end

    cpe_cfg_ram u_cfg_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_idx  (n_req.word_idx),
        .i_wr_en   (exec_done && result.mem_we),
        .i_wr_idx  (r_req.word_idx),
        .i_wr_data (result.mem_wdata),
        .o_rd_data (mem_word)
    );

    cpe_access_unit u_access (
        .i_req         (r_req),
        .i_addr_latch  (r_addr_latch),
        .i_word        (mem_word),
        .i_region_size (r_region_size),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req <= n_req;
        end
        if (exec_done) begin
            r_out_rdata  <= result.read_data;
            r_out_status <= result.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_addr_latch  <= '0;
            r_region_size <= {cpe_pkg::NumBars{cpe_pkg::BarSizeReset}};
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (exec_done && result.latch_we) begin
                r_addr_latch <= r_req.write_data;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cpe_pkg::RegBar0Size: r_region_size[0] <= i_cfg_wdata;
                    cpe_pkg::RegBar1Size: r_region_size[1] <= i_cfg_wdata;
                    cpe_pkg::RegBar2Size: r_region_size[2] <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_status, r_out_rdata};

    // Only one transaction is in flight: the port closes right after a take.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_axis_tready)
        else $error("transaction accepted while another is in flight");

    // Rejected and ignored transactions return no data.
    a_no_data_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[33:32] != cpe_pkg::ST_DONE)
            |-> m_axis_tdata[31:0] == 32'd0)
        else $error("read data returned with a failing status");

    // The write-back only happens in the cycle that completes a data-port write with status done.
    a_write_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_done && result.mem_we) |-> result.status == cpe_pkg::ST_DONE
            && r_req.opcode == cpe_pkg::OpWrite && r_req.port_offset[2])
        else $error("configuration space written by a non-data-port write");

    // The address latch only changes as a transaction completes.
    a_latch_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec_done |=> $stable(r_addr_latch))
        else $error("address latch changed outside a transaction");

endmodule

`default_nettype wire
